[design/assert_macros.svh]
// assertion macros used by the checker file of this project
// no dependencies; each macro wraps one concurrent assertion with a reset guard
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SPCG_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define SPCG_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[design/spcg_pkg.sv]
// shared types, constants and the cordic arctangent table of the scan gate
// no dependencies; used by the controller, datapath and top level
package spcg_pkg;

  // scan geometry and cordic limits
  localparam int EDGE_MARGIN      = 16;
  localparam int MAX_BEAMS        = 4096;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  // cordic gain compensation, 2^30 scaled
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // output clamp limits
  localparam int X_LIMIT = 66535;
  localparam int Y_LIMIT = 65535;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RANGE_LOW  = 3'd0,
    REG_RANGE_HIGH = 3'd1,
    REG_ANGLE_START = 3'd2,
    REG_ANGLE_STEP = 3'd3,
    REG_BEAM_COUNT = 3'd4,
    REG_SENSOR_OFFSET = 3'd5
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_INIT,
    ST_ROT,
    ST_QUAD,
    ST_EMIT
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic init;
    logic step;
    logic quad;
    logic emit;
  } dp_cmd_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051D;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2E;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2F9;
      5'd15: v = 32'sh0000517C;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A2F;
      5'd19: v = 32'sh00000517;
      5'd20: v = 32'sh0000028B;
      5'd21: v = 32'sh00000145;
      5'd22: v = 32'sh000000A2;
      5'd23: v = 32'sh00000051;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

[design/scan_polar_to_cartesian_gate.sv]
// top level of the scan gate: joins the sequencer and the datapath
// depends on spcg_pkg, spcg_ctrl and spcg_dp
//
// Usage
//   Input channel: one beat per laser sample (range_mm, range_is_nan,
//   beam_index), taken on in_valid high with in_stall low. Output channel:
//   one beat per sample with x_mm, y_mm, point_valid and the nearest-range
//   tracking state after that sample, taken on out_valid high with
//   out_stall low. Registers are written over cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high, so a write lands in
//   the cycle it is offered. Write registers only while the block is idle.
//   One cordic micro-rotation per cycle through a single shared shift-add
//   unit. A sample is taken only while the sequencer is idle, so the
//   next one is held off until the current one has been emitted; the
//   iterative cordic sets the rate. A new sample is taken while the
//   previous result still waits in the output register.
//   If the receiver stalls, the finished result is held and the next sample
//   waits at the emit step until the output register is free.
//   Reset clears the sequencer, loads the register defaults and clears the
//   nearest-range tracking (range 65535, beam 0, not found).
module scan_polar_to_cartesian_gate #(
  parameter int CORDIC_STEPS = spcg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      range_mm,
  input  logic                             range_is_nan,
  input  logic [11:0]                      beam_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [17:0]               x_mm,
  output logic signed [16:0]               y_mm,
  output logic                             point_valid,
  output logic [15:0]                      nearest_range_mm,
  output logic [11:0]                      nearest_beam,
  output logic                             nearest_found,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [spcg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [spcg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int Steps = (CORDIC_STEPS > spcg_pkg::ATAN_LEN) ? spcg_pkg::ATAN_LEN
                                                            : CORDIC_STEPS;
  localparam int StepW = $clog2(Steps);

  spcg_pkg::dp_cmd_t cmd;
  logic [StepW-1:0]  step_idx;

  // register writes never wait
  assign cfg_ready = 1'b1;

  // sequencer
  spcg_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .step_idx (step_idx)
  );

  // datapath
  spcg_dp #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .step_idx        (step_idx),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .range_mm        (range_mm),
    .range_is_nan    (range_is_nan),
    .beam_index      (beam_index),
    .x_mm            (x_mm),
    .y_mm            (y_mm),
    .point_valid     (point_valid),
    .nearest_range_mm(nearest_range_mm),
    .nearest_beam    (nearest_beam),
    .nearest_found   (nearest_found)
  );

endmodule

[design/spcg_ctrl.sv]
// sequencer of the scan gate: steps one sample through the datapath
// depends on spcg_pkg for the state and command types
module spcg_ctrl #(
  parameter int CORDIC_STEPS = spcg_pkg::CORDIC_STEPS_DEF,
  localparam int Steps = (CORDIC_STEPS > spcg_pkg::ATAN_LEN) ? spcg_pkg::ATAN_LEN
                                                            : CORDIC_STEPS,
  localparam int StepW = $clog2(Steps)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output spcg_pkg::dp_cmd_t   cmd,
  output logic [StepW-1:0]    step_idx
);

  localparam logic [StepW-1:0] LastStep = StepW'(Steps - 1);

  spcg_pkg::state_t state, state_next;
  logic             out_free;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != spcg_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spcg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      spcg_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = spcg_pkg::ST_PREP;
        end
      end
      spcg_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = spcg_pkg::ST_INIT;
      end
      spcg_pkg::ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = spcg_pkg::ST_ROT;
      end
      spcg_pkg::ST_ROT: begin
        cmd.step = 1'b1;
        if (step_idx == LastStep) begin
          state_next = spcg_pkg::ST_QUAD;
        end
      end
      spcg_pkg::ST_QUAD: begin
        cmd.quad   = 1'b1;
        state_next = spcg_pkg::ST_EMIT;
      end
      spcg_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = spcg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spcg_pkg::ST_IDLE;
      end
    endcase
  end

  // cordic step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step_idx <= '0;
    end else if (cmd.init) begin
      step_idx <= '0;
    end else if (cmd.step) begin
      step_idx <= step_idx + StepW'(1);
    end
  end

  // result beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[design/spcg_dp.sv]
// datapath of the scan gate: config registers, gating, iterative cordic,
// output clamp and nearest-range tracking; depends on spcg_pkg
module spcg_dp #(
  parameter int CORDIC_STEPS = spcg_pkg::CORDIC_STEPS_DEF,
  localparam int Steps = (CORDIC_STEPS > spcg_pkg::ATAN_LEN) ? spcg_pkg::ATAN_LEN
                                                            : CORDIC_STEPS,
  localparam int StepW = $clog2(Steps)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spcg_pkg::dp_cmd_t                   cmd,
  input  logic [StepW-1:0]                    step_idx,
  input  logic                                cfg_wr,
  input  logic [spcg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [spcg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [15:0]                         range_mm,
  input  logic                                range_is_nan,
  input  logic [11:0]                         beam_index,
  output logic signed [17:0]                  x_mm,
  output logic signed [16:0]                  y_mm,
  output logic                                point_valid,
  output logic [15:0]                         nearest_range_mm,
  output logic [11:0]                         nearest_beam,
  output logic                                nearest_found
);

  localparam logic [17:0] EdgeMargin = 18'(spcg_pkg::EDGE_MARGIN);
  localparam logic [16:0] MaxBeams   = 17'(spcg_pkg::MAX_BEAMS);
  localparam logic signed [20:0] XLim = 21'(spcg_pkg::X_LIMIT);
  localparam logic signed [20:0] YLim = 21'(spcg_pkg::Y_LIMIT);

  // configuration registers
  logic [15:0]        range_low;
  logic [15:0]        range_high;
  logic [15:0]        angle_start;
  logic [15:0]        angle_step;
  logic [12:0]        beam_count;
  logic signed [10:0] sensor_offset;

  // sample registers
  logic [15:0] samp_range;
  logic        samp_nan;
  logic [11:0] samp_idx;
  logic        samp_valid;
  logic [15:0] angle;
  logic [1:0]  quad;

  // cordic vector
  logic signed [35:0] cx, cy;
  logic signed [31:0] cz;
  logic signed [19:0] xr, yr;

  // tracking state
  logic [15:0] best_range;
  logic [11:0] best_beam;
  logic        best_seen;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low     <= 16'd20;
      range_high    <= 16'd5600;
      angle_start   <= 16'd43691;
      angle_step    <= 16'd96;
      beam_count    <= 13'd682;
      sensor_offset <= 11'sd160;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        spcg_pkg::REG_RANGE_LOW:     range_low     <= cfg_data;
        spcg_pkg::REG_RANGE_HIGH:    range_high    <= cfg_data;
        spcg_pkg::REG_ANGLE_START:   angle_start   <= cfg_data;
        spcg_pkg::REG_ANGLE_STEP:    angle_step    <= cfg_data;
        spcg_pkg::REG_BEAM_COUNT:    beam_count    <= cfg_data[12:0];
        spcg_pkg::REG_SENSOR_OFFSET: sensor_offset <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // edge, nan and window gating
  logic [16:0]        beam_lim;
  logic signed [17:0] upper_lim;
  logic [17:0]        idx_ext;
  logic               in_edge;
  logic               valid_c;

  always_comb begin
    beam_lim  = ({4'b0, beam_count} > MaxBeams) ? MaxBeams : {4'b0, beam_count};
    upper_lim = $signed({1'b0, beam_lim}) - $signed(EdgeMargin);
    idx_ext   = {6'b0, samp_idx};
    in_edge   = (idx_ext < EdgeMargin) || ($signed(idx_ext) > upper_lim);
    valid_c   = !in_edge && !samp_nan && (samp_range >= range_low)
                && (samp_range <= range_high);
  end

  // beam angle and gain-scaled start vector
  logic [27:0] angle_prod;
  logic [15:0] angle_c;
  logic [45:0] gain_prod;

  assign angle_prod = 28'(samp_idx) * 28'(angle_step);
  assign angle_c    = angle_start + angle_prod[15:0];
  assign gain_prod  = 46'(samp_range) * 46'(spcg_pkg::GAIN_Q30);

  // quadrant split of the angle
  logic [15:0] qsum;
  logic [15:0] resid;

  assign qsum  = angle + 16'h2000;
  assign resid = angle - {qsum[15:14], 14'b0};

  // one cordic micro-rotation
  logic signed [35:0] dx, dy;
  logic signed [31:0] atan_c;

  assign dx     = cy >>> step_idx;
  assign dy     = cx >>> step_idx;
  assign atan_c = spcg_pkg::atan_turn(5'(step_idx));

  // quadrant rotation and rounding to millimetres
  logic signed [35:0] xq, yq, xq_rnd, yq_rnd;

  always_comb begin
    case (quad)
      2'd1: begin
        xq = -cy;
        yq = cx;
      end
      2'd2: begin
        xq = -cx;
        yq = -cy;
      end
      2'd3: begin
        xq = cy;
        yq = -cx;
      end
      default: begin
        xq = cx;
        yq = cy;
      end
    endcase
    xq_rnd = xq + 36'sd32768;
    yq_rnd = yq + 36'sd32768;
  end

  // offset and clamp
  logic signed [20:0] xs, ys, x_cl, y_cl;

  always_comb begin
    xs = {xr[19], xr} + {{10{sensor_offset[10]}}, sensor_offset};
    ys = {yr[19], yr};
    if (xs > XLim) begin
      x_cl = XLim;
    end else if (xs < -XLim) begin
      x_cl = -XLim;
    end else begin
      x_cl = xs;
    end
    if (ys > YLim) begin
      y_cl = YLim;
    end else if (ys < -YLim) begin
      y_cl = -YLim;
    end else begin
      y_cl = ys;
    end
  end

  // sample and cordic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp_range <= range_mm;
      samp_nan   <= range_is_nan;
      samp_idx   <= beam_index;
    end
    if (cmd.prep) begin
      samp_valid <= valid_c;
      angle      <= angle_c;
      cx         <= {4'b0, gain_prod[45:14]};
    end
    if (cmd.init) begin
      quad <= qsum[15:14];
      cy   <= '0;
      cz   <= {resid, 16'h0};
    end
    if (cmd.step) begin
      if (cz >= 0) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - atan_c;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + atan_c;
      end
    end
    if (cmd.quad) begin
      xr <= xq_rnd[35:16];
      yr <= yq_rnd[35:16];
    end
    if (cmd.emit) begin
      point_valid <= samp_valid;
      x_mm        <= samp_valid ? x_cl[17:0] : '0;
      y_mm        <= samp_valid ? y_cl[16:0] : '0;
    end
  end

  // nearest tracking, restarted at beam zero
  logic [15:0] base_range;
  logic [11:0] base_beam;
  logic        base_seen;
  logic        take;

  always_comb begin
    if (samp_idx == 12'd0) begin
      base_range = 16'hFFFF;
      base_beam  = 12'd0;
      base_seen  = 1'b0;
    end else begin
      base_range = best_range;
      base_beam  = best_beam;
      base_seen  = best_seen;
    end
    take = samp_valid && (!base_seen || (samp_range < base_range));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_range <= 16'hFFFF;
      best_beam  <= 12'd0;
      best_seen  <= 1'b0;
    end else if (cmd.emit) begin
      best_range <= take ? samp_range : base_range;
      best_beam  <= take ? samp_idx : base_beam;
      best_seen  <= take || base_seen;
    end
  end

  assign nearest_range_mm = best_range;
  assign nearest_beam     = best_beam;
  assign nearest_found    = best_seen;

endmodule

[design/spcg_checker.sv]
// port-level checks of the scan gate, bound to the top level
// depends on assert_macros.svh and scan_polar_to_cartesian_gate
`include "assert_macros.svh"

module spcg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] x_mm,
  input logic signed [16:0] y_mm,
  input logic               point_valid,
  input logic [15:0]        nearest_range_mm,
  input logic [11:0]        nearest_beam,
  input logic               nearest_found
);

  // a rejected sample carries no coordinates
  `SPCG_ASSERT_IMPL(a_zero_when_invalid, clk, rst, out_valid && !point_valid, x_mm == 18'sd0 && y_mm == 17'sd0, "invalid point with nonzero coordinates")

  // one sample at a time: busy right after a take
  `SPCG_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "sample taken while previous still in flight")

  // empty tracking reads as its cleared values
  `SPCG_ASSERT_IMPL(a_empty_tracking, clk, rst, !nearest_found, nearest_range_mm == 16'hFFFF && nearest_beam == 12'd0, "tracking not cleared while nothing found")

  // a valid point always leaves the tracking with a nearest range found
  `SPCG_ASSERT_IMPL(a_found_with_point, clk, rst, out_valid && point_valid, nearest_found, "valid point without nearest found")

  // a stalled result holds
  `SPCG_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid && $stable(x_mm) && $stable(y_mm), "stalled result changed")

endmodule

bind scan_polar_to_cartesian_gate spcg_checker u_spcg_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .x_mm            (x_mm),
  .y_mm            (y_mm),
  .point_valid     (point_valid),
  .nearest_range_mm(nearest_range_mm),
  .nearest_beam    (nearest_beam),
  .nearest_found   (nearest_found)
);
